/* sv/csi_pkg.sv */
package csi_pkg;

	// Number of rotation cells requested, and the length of the arctangent table.
	localparam int ANGLE_STAGES = 16;
	localparam int TABLE_LEN    = 30;
	localparam int ROT_STAGES   = (ANGLE_STAGES < TABLE_LEN) ? ANGLE_STAGES : TABLE_LEN;

	// Normalization shifts 32, 16, 8, 4, 2, 1.
	localparam int NORM_STAGES  = 6;
	localparam int NORM_TOP     = 33;

	localparam int CW   = 32;   // curvature width
	localparam int SW   = 33;   // exact sum and difference width
	localparam int MW   = 34;   // magnitude width
	localparam int XW   = 38;   // rotation datapath width
	localparam int ZW   = 32;   // angle accumulator width
	localparam int RW   = 16;   // result width
	localparam int IDXW = 5;    // rotation stage index width
	localparam int SHW  = 6;    // normalization shift width

	localparam logic signed [RW-1:0] Q14_ONE = 16'sd16384;

	localparam logic signed [ZW-1:0] ANGLE_TAB [TABLE_LEN] = '{
		32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
		32'sd42667331, 32'sd21354465, 32'sd10679838, 32'sd5340245,
		32'sd2670163, 32'sd1335087, 32'sd667544, 32'sd333772,
		32'sd166886, 32'sd83443, 32'sd41722, 32'sd20861,
		32'sd10430, 32'sd5215, 32'sd2608, 32'sd1304,
		32'sd652, 32'sd326, 32'sd163, 32'sd81,
		32'sd41, 32'sd20, 32'sd10, 32'sd5,
		32'sd3, 32'sd1
	};

	// One point in flight through the chain.
	typedef struct packed {
		logic                 undef;
		logic                 equal;
		logic                 sum_neg;
		logic [MW-1:0]        mag;
		logic signed [XW-1:0] x;
		logic signed [XW-1:0] y;
		logic signed [ZW-1:0] z;
	} item_t;

	function automatic logic [SHW-1:0] norm_shift(input int j);
		norm_shift = SHW'(32 >> j);
	endfunction

endpackage

/* sv/csi_if.sv */
interface csi_in_if;
	import csi_pkg::*;
	logic                 valid;
	logic                 ready;
	logic signed [CW-1:0] first_curvature;
	logic signed [CW-1:0] second_curvature;
	modport source (output valid, output first_curvature, output second_curvature,
		input ready);
	modport sink (input valid, input first_curvature, input second_curvature,
		output ready);
endinterface

interface csi_out_if;
	import csi_pkg::*;
	logic                 valid;
	logic                 ready;
	logic signed [RW-1:0] shape_index;
	logic                 undefined;
	modport source (output valid, output shape_index, output undefined, input ready);
	modport sink (input valid, input shape_index, input undefined, output ready);
endinterface

/* sv/curvature_shape_index.sv */
// Shape index of one surface point from its two principal curvatures.
// The points channel takes first_curvature and second_curvature, both signed
// Q16.16. The indices channel returns shape_index in signed Q2.14, from -1 to
// +1, and the undefined flag, which is set (with shape_index zero) when both
// curvatures are zero. Equal nonzero curvatures give exactly +1 or -1.
// Every word in gives exactly one word out, in order.
// The path is a sum and difference register, six normalization cells, one cell
// per arctangent rotation and an output register. A new word is taken every
// cycle while the receiver does not stall.
// Each cell holds its own valid bit and advances when it is empty or when the
// cell after it advances, so bubbles close up; when the receiver stalls the
// chain keeps taking words until every cell is full, then ready drops.
// Reset clears all valid bits; the block is ready right after reset.
module curvature_shape_index
	import csi_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	csi_in_if.sink     points,
	csi_out_if.source  indices
);

	localparam int NCELL = NORM_STAGES + ROT_STAGES;

	logic  stage_v   [NCELL+1];
	item_t stage_d   [NCELL+1];
	logic  stage_adv [NCELL+2];

	logic signed [SW-1:0] sum;
	logic signed [SW-1:0] dif;
	logic [MW-1:0]        sum_mag;
	item_t                prep;

	logic                 out_v_q;
	logic                 out_adv;
	logic signed [RW-1:0] res_q;
	logic                 undef_q;
	logic signed [RW-1:0] res_nxt;
	logic signed [ZW+1:0] rnd;

	// Sum and absolute difference do not depend on which curvature is larger.
	always_comb begin
		sum = SW'(points.first_curvature) + SW'(points.second_curvature);
		if (points.first_curvature >= points.second_curvature) begin
			dif = SW'(points.first_curvature) - SW'(points.second_curvature);
		end else begin
			dif = SW'(points.second_curvature) - SW'(points.first_curvature);
		end
		sum_mag = sum[SW-1] ? MW'(-(MW'(sum))) : MW'(sum);
		prep.undef   = (dif == '0) && (sum == '0);
		prep.equal   = (dif == '0);
		prep.sum_neg = sum[SW-1];
		prep.mag     = (sum_mag > MW'(dif)) ? sum_mag : MW'(dif);
		prep.x       = XW'(dif);
		prep.y       = XW'(sum);
		prep.z       = '0;
	end

	assign stage_adv[0]       = !stage_v[0] || stage_adv[1];
	assign stage_adv[NCELL+1] = out_adv;
	assign points.ready       = stage_adv[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_v[0] <= 1'b0;
		end else if (stage_adv[0]) begin
			stage_v[0] <= points.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (stage_adv[0]) begin
			stage_d[0] <= prep;
		end
	end

	for (genvar g = 0; g < NORM_STAGES; g++) begin : g_norm
		csi_norm_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.shift   (norm_shift(g)),
			.v_in    (stage_v[g]),
			.d_in    (stage_d[g]),
			.adv_out (stage_adv[g+2]),
			.v_q     (stage_v[g+1]),
			.d_q     (stage_d[g+1]),
			.adv     (stage_adv[g+1])
		);
	end

	for (genvar g = 0; g < ROT_STAGES; g++) begin : g_rot
		csi_rot_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.idx     (IDXW'(g)),
			.v_in    (stage_v[NORM_STAGES+g]),
			.d_in    (stage_d[NORM_STAGES+g]),
			.adv_out (stage_adv[NORM_STAGES+g+2]),
			.v_q     (stage_v[NORM_STAGES+g+1]),
			.d_q     (stage_d[NORM_STAGES+g+1]),
			.adv     (stage_adv[NORM_STAGES+g+1])
		);
	end

	// The index is the negated angle, rounded to Q2.14 and clamped to +-1; undefined and equal words take 0 or +-1.
	always_comb begin
		rnd = (-(ZW'(0) + (ZW+2)'(stage_d[NCELL].z))) + (ZW+2)'(33'sd32768);
		rnd = rnd >>> 16;
		if (stage_d[NCELL].undef) begin
			res_nxt = '0;
		end else if (stage_d[NCELL].equal) begin
			res_nxt = stage_d[NCELL].sum_neg ? -Q14_ONE : Q14_ONE;
		end else if (rnd > (ZW+2)'(Q14_ONE)) begin
			res_nxt = Q14_ONE;
		end else if (rnd < -((ZW+2)'(Q14_ONE))) begin
			res_nxt = -Q14_ONE;
		end else begin
			res_nxt = RW'(rnd);
		end
	end

	assign out_adv = !out_v_q || indices.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (out_adv) begin
			out_v_q <= stage_v[NCELL];
		end
	end

	always_ff @(posedge clk) begin
		if (out_adv) begin
			res_q   <= res_nxt;
			undef_q <= stage_d[NCELL].undef;
		end
	end

	assign indices.valid       = out_v_q;
	assign indices.shape_index = res_q;
	assign indices.undefined   = undef_q;

`ifndef NO_ASSERTIONS
	a_undef_zero: assert property (@(posedge clk) disable iff (!arst_n)
		indices.valid && indices.undefined |-> indices.shape_index == '0)
		else $error("undefined word carries a nonzero index");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		indices.valid |-> (indices.shape_index <= Q14_ONE) &&
			(indices.shape_index >= -Q14_ONE))
		else $error("shape index outside -1 .. +1");

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_v_q |-> points.ready)
		else $error("input stalled while the output register is empty");

	a_word_moves: assert property (@(posedge clk) disable iff (!arst_n)
		stage_v[NCELL] && out_adv |=> out_v_q)
		else $error("word from the last cell was lost");
`endif

endmodule

/* sv/csi_norm_cell.sv */
module csi_norm_cell
	import csi_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	input  logic [SHW-1:0] shift,
	input  logic           v_in,
	input  item_t          d_in,
	input  logic           adv_out,
	output logic           v_q,
	output item_t          d_q,
	output logic           adv
);

	logic  fits;
	item_t nxt;

	assign adv = !v_q || adv_out;

	// Shift only when the magnitude stays below 2^33 afterwards.
	always_comb begin
		fits = ((d_in.mag >> (SHW'(NORM_TOP) - shift)) == '0);
		nxt  = d_in;
		if (fits) begin
			nxt.mag = d_in.mag << shift;
			nxt.x   = d_in.x <<< shift;
			nxt.y   = d_in.y <<< shift;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (adv) begin
			v_q <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			d_q <= nxt;
		end
	end

endmodule

/* sv/csi_rot_cell.sv */
module csi_rot_cell
	import csi_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic [IDXW-1:0] idx,
	input  logic            v_in,
	input  item_t           d_in,
	input  logic            adv_out,
	output logic            v_q,
	output item_t           d_q,
	output logic            adv
);

	logic signed [XW-1:0] xs;
	logic signed [XW-1:0] ys;
	item_t                nxt;

	assign adv = !v_q || adv_out;

	// Vectoring rotation: drive y toward zero, accumulate the angle in z.
	always_comb begin
		xs  = d_in.x >>> idx;
		ys  = d_in.y >>> idx;
		nxt = d_in;
		if (!d_in.y[XW-1]) begin
			nxt.x = d_in.x + ys;
			nxt.y = d_in.y - xs;
			nxt.z = d_in.z + ANGLE_TAB[idx];
		end else begin
			nxt.x = d_in.x - ys;
			nxt.y = d_in.y + xs;
			nxt.z = d_in.z - ANGLE_TAB[idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (adv) begin
			v_q <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			d_q <= nxt;
		end
	end

endmodule
